FILE: hw/rtl/csp_pkg.sv
// Shared types and constants for the CDMA spread-and-superpose block.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package csp_pkg;

    // Fixed field widths of the command and result ports
    localparam int CODE_BITS = 32;
    localparam int MSG_BITS  = 8;
    localparam int IDX_BITS  = 8;
    localparam int CHIP_BITS = 8;

    // Defaults of the top-level parameters
    localparam int CODE_LENGTH_DEF    = 32;
    localparam int MESSAGE_LENGTH_DEF = 8;
    localparam int FRAME_CHIPS_DEF    = 256;

    // Chip accumulators saturate symmetrically
    localparam logic signed [CHIP_BITS-1:0] SAT_MAX = 8'sd127;
    localparam logic signed [CHIP_BITS-1:0] SAT_MIN = -8'sd127;

    // Reciprocal shift for chip_index / CODE_LENGTH
    localparam int DIV_SHIFT = 16;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic                 command;
        logic [CODE_BITS-1:0] spreading_code;
        logic [MSG_BITS-1:0]  message_bits;
        logic [IDX_BITS-1:0]  chip_index;
    } t_in_item;

    typedef struct packed {
        logic signed [CHIP_BITS-1:0] chip_value;
        logic [IDX_BITS-1:0]         chip_position;
    } t_out_item;

    // Decoded item handed from front to back
    typedef struct packed {
        logic                 is_read;
        logic                 oob;
        logic [CODE_BITS-1:0] code;
        logic [MSG_BITS-1:0]  msg;
        logic [IDX_BITS-1:0]  idx;
        logic [IDX_BITS-1:0]  quot;
    } t_op;

endpackage

`default_nettype wire

FILE: hw/rtl/csp_front.sv
// Front end: takes command items, classifies them and finds the frame row of a read.
// Depends on csp_pkg.
`default_nettype none

module csp_front #(
    parameter int CODE_LENGTH = csp_pkg::CODE_LENGTH_DEF,
    parameter int FRAME_CHIPS = csp_pkg::FRAME_CHIPS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire csp_pkg::t_in_item i_item,
    input  wire logic              i_hold,
    input  wire logic              i_full,
    output logic                   o_busy,
    output logic                   o_push,
    output csp_pkg::t_op           o_op
);

    localparam int DIV_MULT = ((1 << csp_pkg::DIV_SHIFT) + CODE_LENGTH - 1) / CODE_LENGTH;
    localparam int PROD_W   = csp_pkg::IDX_BITS + csp_pkg::DIV_SHIFT + 1;

    logic              r_valid, n_valid;
    csp_pkg::t_op      r_op, n_op;
    logic              accept;
    logic [PROD_W-1:0] prod;

    assign o_busy = i_hold || (r_valid && i_full);
    assign accept = i_start && !o_busy;
    assign o_push = r_valid && !i_full;
    assign o_op   = r_op;

    // exact quotient for any 8-bit index: 2^DIV_SHIFT covers 256 * CODE_LENGTH
    assign prod = PROD_W'(i_item.chip_index) * PROD_W'(DIV_MULT);

    always_comb begin
        n_valid = r_valid && !o_push;
        n_op    = r_op;
        if (accept) begin
            n_valid    = 1'b1;
            n_op.is_read = (i_item.command == csp_pkg::CMD_READ);
            n_op.oob   = (32'(i_item.chip_index) >= FRAME_CHIPS);
            n_op.code  = i_item.spreading_code;
            n_op.msg   = i_item.message_bits;
            n_op.idx   = i_item.chip_index;
            n_op.quot  = prod[csp_pkg::DIV_SHIFT +: csp_pkg::IDX_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/csp_queue.sv
// Short queue of decoded items between front and back.
// Depends on csp_pkg.
`default_nettype none

module csp_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire csp_pkg::t_op i_data,
    input  wire logic         i_pop,
    output logic              o_full,
    output logic              o_valid,
    output csp_pkg::t_op      o_head
);

    localparam int PTR_W = $clog2(csp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(csp_pkg::QUEUE_DEPTH + 1);

    csp_pkg::t_op     r_slot [csp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(csp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wptr] <= i_data;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/csp_back.sv
// Back end: chip frame memory, clearing pass, add and read-clear sequencer, result register.
// Depends on csp_pkg.
`default_nettype none

module csp_back #(
    parameter int CODE_LENGTH    = csp_pkg::CODE_LENGTH_DEF,
    parameter int MESSAGE_LENGTH = csp_pkg::MESSAGE_LENGTH_DEF,
    parameter int FRAME_CHIPS    = csp_pkg::FRAME_CHIPS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_valid,
    input  wire csp_pkg::t_op i_q_head,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_result_valid,
    output csp_pkg::t_out_item o_result
);

    localparam int CW       = csp_pkg::CHIP_BITS;
    localparam int ROWS     = (FRAME_CHIPS + CODE_LENGTH - 1) / CODE_LENGTH;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_SPAN = 1 << ROW_W;
    localparam int LANE_W   = $clog2(CODE_LENGTH);
    localparam int WORD_W   = CODE_LENGTH * CW;
    localparam int ADD_ROWS = (MESSAGE_LENGTH < ROWS) ? MESSAGE_LENGTH : ROWS;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0] ADD_LAST = ROW_W'(ADD_ROWS - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ADD   = 4'b0100,
        S_RD    = 4'b1000
    } t_back_state;

    t_back_state                  r_state, n_state;
    logic [ROW_W-1:0]             r_row, n_row;
    logic [csp_pkg::CODE_BITS-1:0] r_code, n_code;
    logic [csp_pkg::MSG_BITS-1:0] r_msg, n_msg;
    logic [LANE_W-1:0]            r_lane, n_lane;
    logic [csp_pkg::IDX_BITS-1:0] r_idx, n_idx;
    logic                         r_out_valid, n_out_valid;
    csp_pkg::t_out_item           r_out, n_out;

    logic [WORD_W-1:0]            r_mem [ROWS];
    logic [WORD_W-1:0]            r_rdata;
    logic                         rd_en, wr_en;
    logic [ROW_W-1:0]             rd_addr, wr_addr;
    logic [WORD_W-1:0]            wr_data;

    logic [ROW_SPAN-1:0]          msg_ext;
    logic [CODE_LENGTH-1:0]       code_ext;
    logic                         msg_bit;
    logic [WORD_W-1:0]            add_row, clr_row;
    logic signed [CW-1:0]         sel_chip;

    // bits past the carried fields count as -1
    for (genvar k = 0; k < ROW_SPAN; k++) begin : g_msg
        if (k < csp_pkg::MSG_BITS) begin : g_in
            assign msg_ext[k] = r_msg[k];
        end else begin : g_out
            assign msg_ext[k] = 1'b0;
        end
    end

    for (genvar k = 0; k < CODE_LENGTH; k++) begin : g_code
        if (k < csp_pkg::CODE_BITS) begin : g_in
            assign code_ext[k] = r_code[k];
        end else begin : g_out
            assign code_ext[k] = 1'b0;
        end
    end

    assign msg_bit  = msg_ext[r_row];
    assign sel_chip = r_rdata[{r_lane, 3'b000} +: CW];

    // one row = one message bit times the whole code; every lane saturates on its own
    always_comb begin
        logic signed [CW-1:0] acc;
        for (int k = 0; k < CODE_LENGTH; k++) begin
            acc = r_rdata[k*CW +: CW];
            if (code_ext[k] == msg_bit) begin
                add_row[k*CW +: CW] = (acc == csp_pkg::SAT_MAX) ? acc : acc + 8'sd1;
            end else begin
                add_row[k*CW +: CW] = (acc == csp_pkg::SAT_MIN) ? acc : acc - 8'sd1;
            end
            clr_row[k*CW +: CW] = (LANE_W'(k) == r_lane) ? '0 : acc;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_code      = r_code;
        n_msg       = r_msg;
        n_lane      = r_lane;
        n_idx       = r_idx;
        n_out_valid = 1'b0;
        n_out       = r_out;
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_row;
        wr_en       = 1'b0;
        wr_addr     = r_row;
        wr_data     = add_row;
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (r_row == LAST_ROW) begin
                    n_row   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (!i_q_head.is_read) begin
                        n_code  = i_q_head.code;
                        n_msg   = i_q_head.msg;
                        n_row   = '0;
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_state = S_ADD;
                    end else if (i_q_head.oob) begin
                        n_out_valid             = 1'b1;
                        n_out.chip_value        = '0;
                        n_out.chip_position     = i_q_head.idx;
                    end else begin
                        n_row   = ROW_W'(i_q_head.quot);
                        rd_en   = 1'b1;
                        rd_addr = ROW_W'(i_q_head.quot);
                        n_lane  = LANE_W'(i_q_head.idx
                                  - csp_pkg::IDX_BITS'(i_q_head.quot * CODE_LENGTH));
                        n_idx   = i_q_head.idx;
                        n_state = S_RD;
                    end
                end
            end
            S_ADD: begin
                wr_en = 1'b1;
                if (r_row == ADD_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_row   = r_row + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = r_row + 1'b1;
                end
            end
            S_RD: begin
                wr_en               = 1'b1;
                wr_data             = clr_row;
                n_out_valid         = 1'b1;
                n_out.chip_value    = sel_chip;
                n_out.chip_position = r_idx;
                n_state             = S_IDLE;
            end
            default: begin
                n_row   = '0;
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_msg  <= n_msg;
        r_lane <= n_lane;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    assign o_clearing     = (r_state == S_CLEAR);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_pop)
        else $error("queue popped during clearing pass");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("row read and written in the same cycle");

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> r_out_valid)
        else $error("read-clear finished without a result");

    a_value_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.chip_value != -8'sd128))
        else $error("chip value outside saturation range");

endmodule

`default_nettype wire

FILE: hw/rtl/cdma_spread_superpose.sv
// Top level of the CDMA spread-and-superpose block: front end, item queue and back end.
// Depends on csp_pkg, csp_front, csp_queue and csp_back.
//
// An item is taken at a rising edge with start high and busy low. An add item
// (command 0) spreads its message over the code and adds the chips into the frame;
// it gives no result. A read item (command 1) gives one result on o_result,
// marked by o_result_valid for exactly one cycle; the receiver cannot
// stall, so take it in that cycle. The back end works on the single frame
// memory, whose word holds one code length of chips: an add does one
// read-modify-write of a row per message bit, over the first min(MESSAGE_LENGTH,
// ceil(FRAME_CHIPS / CODE_LENGTH)) rows; a read-clear reads its row, gives the
// chip and writes the row back with that chip zeroed; a read outside the frame
// gives 0 without touching the memory. The front end and a two-entry queue take
// items while the back end works, so outside the clearing pass busy rises only
// once the queue and front register are full. After reset a clearing pass zeroes
// all ceil(FRAME_CHIPS / CODE_LENGTH) rows with busy high. Results keep read order.
`default_nettype none

module cdma_spread_superpose #(
    parameter int CODE_LENGTH    = csp_pkg::CODE_LENGTH_DEF,
    parameter int MESSAGE_LENGTH = csp_pkg::MESSAGE_LENGTH_DEF,
    parameter int FRAME_CHIPS    = csp_pkg::FRAME_CHIPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire csp_pkg::t_in_item  i_item,
    output logic                    busy,
    output logic                    o_result_valid,
    output csp_pkg::t_out_item      o_result
);

    logic         push, full, q_valid, pop, clearing;
    csp_pkg::t_op front_op, q_head;

    // accept and classify; hold off while the frame is being cleared
    csp_front #(
        .CODE_LENGTH (CODE_LENGTH),
        .FRAME_CHIPS (FRAME_CHIPS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_hold  (clearing),
        .i_full  (full),
        .o_busy  (busy),
        .o_push  (push),
        .o_op    (front_op)
    );

    // decouple the two halves
    csp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_op),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // carry out adds and read-clears on the frame memory
    csp_back #(
        .CODE_LENGTH    (CODE_LENGTH),
        .MESSAGE_LENGTH (MESSAGE_LENGTH),
        .FRAME_CHIPS    (FRAME_CHIPS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_head       (q_head),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire
